[rtl/cad_pkg.sv]
`default_nettype none

package cad_pkg;

    // pipeline depth
    localparam int CAD_ITERATIONS = 10;
    localparam int CAD_PRE_STAGES = 4;

    // widths: datapath is wide enough that x, y never wrap
    localparam int CAD_DW     = 36;
    localparam int CAD_AW     = 25;
    localparam int CAD_IN_W   = 32;
    localparam int CAD_OUT_W  = 32;
    localparam int CAD_UPSHIFT = 12;

    typedef logic signed [CAD_DW-1:0] cad_word_t;
    typedef logic signed [CAD_AW-1:0] cad_angle_t;

    // one item in flight: vector, angle accumulator, zero-y bypass flag
    typedef struct packed {
        cad_word_t  x;
        cad_word_t  y;
        cad_angle_t acc;
        logic       skip;
    } cad_item_t;

    // angles in signed 9.16 degrees
    localparam cad_angle_t DEG_ZERO = 25'sd0;
    localparam cad_angle_t DEG45    = 25'sd2949120;
    localparam cad_angle_t DEG90    = 25'sd5898240;
    localparam cad_angle_t DEG180   = 25'sd11796480;

    localparam cad_word_t ZERO_W = 36'sd0;
    localparam cad_word_t ONE_FX = 36'sd65536;

    // atan(2^-i) in 9.16 degrees, i = 0..12
    localparam cad_angle_t ATAN_TABLE [0:12] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334,
        25'sd3667, 25'sd1833, 25'sd917
    };

endpackage

`default_nettype wire

[rtl/cad_prerot.sv]
`default_nettype none

module cad_prerot (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           in_y,
    input  logic [31:0]           in_x,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cad_pkg::cad_item_t    out_item
);
    import cad_pkg::*;

    logic [CAD_PRE_STAGES-1:0] valid_reg;
    logic [CAD_PRE_STAGES-1:0] stage_ready;
    cad_item_t                 item_reg  [CAD_PRE_STAGES];
    cad_item_t                 item_next [CAD_PRE_STAGES];

    // per-stage ready: a stage moves when empty or when the next one moves
    always_comb begin
        stage_ready[CAD_PRE_STAGES-1] = !valid_reg[CAD_PRE_STAGES-1] || out_ready;
        for (int k = CAD_PRE_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[CAD_PRE_STAGES-1];
    assign out_item  = item_reg[CAD_PRE_STAGES-1];

    // stage 0: sign-extend, zero-y bypass, fold lower half plane (-180)
    always_comb begin
        cad_word_t xw;
        cad_word_t yw;
        xw = {{(CAD_DW-CAD_IN_W){in_x[CAD_IN_W-1]}}, in_x};
        yw = {{(CAD_DW-CAD_IN_W){in_y[CAD_IN_W-1]}}, in_y};
        item_next[0].skip = (in_y == '0);
        if (in_y == '0) begin
            item_next[0].acc = in_x[CAD_IN_W-1] ? DEG180 : DEG_ZERO;
            item_next[0].x   = xw;
            item_next[0].y   = yw;
        end else if (in_y[CAD_IN_W-1]) begin
            item_next[0].acc = -DEG180;
            item_next[0].x   = -xw;
            item_next[0].y   = -yw;
        end else begin
            item_next[0].acc = DEG_ZERO;
            item_next[0].x   = xw;
            item_next[0].y   = yw;
        end
    end

    // stage 1: rotate by -90 when x <= 0
    always_comb begin
        item_next[1] = item_reg[0];
        if (!item_reg[0].skip && item_reg[0].x <= ZERO_W) begin
            item_next[1].x   = item_reg[0].y;
            item_next[1].y   = -item_reg[0].x;
            item_next[1].acc = item_reg[0].acc + DEG90;
        end
    end

    // stage 2: rotate by -45 when x <= y
    always_comb begin
        item_next[2] = item_reg[1];
        if (!item_reg[1].skip && item_reg[1].x <= item_reg[1].y) begin
            item_next[2].x   = item_reg[1].x + item_reg[1].y;
            item_next[2].y   = item_reg[1].y - item_reg[1].x;
            item_next[2].acc = item_reg[1].acc + DEG45;
        end
    end

    // stage 3: scale small vectors up by 4096
    always_comb begin
        item_next[3] = item_reg[2];
        if (!item_reg[2].skip && item_reg[2].x < ONE_FX) begin
            item_next[3].x = item_reg[2].x <<< CAD_UPSHIFT;
            item_next[3].y = item_reg[2].y <<< CAD_UPSHIFT;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < CAD_PRE_STAGES; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        for (int k = 0; k < CAD_PRE_STAGES; k++) begin
            if (stage_ready[k]) begin
                item_reg[k] <= item_next[k];
            end
        end
    end

    // an accepted beat lands in the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted beat missing from first stage");

    // folded vector lies in the first octant
    a_octant: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_item.skip |->
            out_item.x > ZERO_W && out_item.y >= ZERO_W && out_item.y < out_item.x)
        else $error("pre-rotation left vector outside first octant");

    // a held output stage keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("pre-rotation output changed while stalled");

endmodule

`default_nettype wire

[rtl/cordic_atan2_degrees.sv]
`default_nettype none
// channel | direction | beat contents (tdata, lowest bit first)
// s_      | in        | y_value[31:0], x_value[63:32], signed 16.16
// m_      | out       | angle[24:0] signed 9.16 degrees, zero pad [31:25]
//
// one beat per cycle sustained while m_tready is high; 4 pre-rotation stages,
// 10 cordic micro-rotation stages, each one register
// aresetn clears only the valid bits; payload registers are not reset
// every stage has its own valid bit and advances when empty or when its
// successor advances, so bubbles close up during an output stall
// m_tvalid comes straight from the last stage register

module cordic_atan2_degrees (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // y_value [31:0], x_value [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // angle [24:0], zero [31:25]
);
    import cad_pkg::*;

    localparam int N = CAD_ITERATIONS;

    logic      pre_valid;
    logic      pre_ready;
    cad_item_t pre_item;

    logic [N-1:0] valid_reg;
    logic [N-1:0] stage_ready;
    logic [N-1:0] src_valid;
    cad_item_t    src_item  [N];
    cad_item_t    item_reg  [N];
    cad_item_t    item_next [N];

    // sign fold, quadrant and octant pre-rotations, upscale
    cad_prerot u_prerot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_y      (s_tdata[31:0]),
        .in_x      (s_tdata[63:32]),
        .out_valid (pre_valid),
        .out_ready (pre_ready),
        .out_item  (pre_item)
    );

    // ready chain through the micro-rotation stages
    always_comb begin
        stage_ready[N-1] = !valid_reg[N-1] || m_tready;
        for (int k = N - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign pre_ready = stage_ready[0];

    // micro-rotation stage g shifts by g+1
    for (genvar g = 0; g < N; g++) begin : g_rot
        if (g == 0) begin : g_first
            assign src_valid[g] = pre_valid;
            assign src_item[g]  = pre_item;
        end else begin : g_next
            assign src_valid[g] = valid_reg[g-1];
            assign src_item[g]  = item_reg[g-1];
        end

        always_comb begin
            item_next[g] = src_item[g];
            if (!src_item[g].skip) begin
                if (!src_item[g].y[CAD_DW-1]) begin
                    item_next[g].x   = src_item[g].x + (src_item[g].y >>> (g + 1));
                    item_next[g].y   = src_item[g].y - (src_item[g].x >>> (g + 1));
                    item_next[g].acc = src_item[g].acc + ATAN_TABLE[g+1];
                end else begin
                    item_next[g].x   = src_item[g].x - (src_item[g].y >>> (g + 1));
                    item_next[g].y   = src_item[g].y + (src_item[g].x >>> (g + 1));
                    item_next[g].acc = src_item[g].acc - ATAN_TABLE[g+1];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= src_valid[k];
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (stage_ready[k]) begin
                item_reg[k] <= item_next[k];
            end
        end
    end

    // output beat from the last stage
    assign m_tvalid = valid_reg[N-1];
    assign m_tdata  = {{(CAD_OUT_W-CAD_AW){1'b0}}, item_reg[N-1].acc};

    // an empty last stage never blocks the input
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[N-1] |-> s_tready)
        else $error("input blocked with empty output stage");

    // bypassed items carry exactly 0 or 180 degrees
    a_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && item_reg[N-1].skip |->
            item_reg[N-1].acc == DEG_ZERO || item_reg[N-1].acc == DEG180)
        else $error("zero-y bypass angle corrupted");

    // result stays within a couple of degrees of the half turn
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            item_reg[N-1].acc <= DEG180 + 25'sd131072 &&
            item_reg[N-1].acc >= -DEG180 - 25'sd131072)
        else $error("angle out of range");

    // a beat moving into the output stage comes from a valid source
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_ready[N-1] && !src_valid[N-1] |=> !m_tvalid)
        else $error("output stage filled without a source beat");

endmodule

`default_nettype wire
